FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checks that a condition implies another in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that a condition implies another in the following cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/twma_pkg.sv
package twma_pkg;

  localparam int DEPTH    = 64;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int SAMPLE_W = 16;
  localparam int TIME_W   = 32;
  localparam int COUNT_W  = 7;
  localparam int SUM_W    = SAMPLE_W + IDX_W;
  localparam int REM_W    = CNT_W + 1;
  localparam int STEP_W   = $clog2(SUM_W + 1);

  localparam logic [TIME_W-1:0] LAG_RESET = TIME_W'(1000);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [TIME_W-1:0]          timestamp;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average;
    logic [COUNT_W-1:0]         count;
  } out_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]          stamp;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DROP_FULL,
    ST_APPEND,
    ST_SETTLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_DELIVER
  } state_t;

  typedef struct packed {
    logic take;
    logic drop;
    logic append;
    logic div_start;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic multi;
    logic aged;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: rtl/time_window_moving_average.sv
// Channel   Direction  Payload      Handshake
// in        input      twma in_t    in_valid / in_stall
// out       output     twma out_t   out_valid / out_stall
// cfg       input      window lag   cfg_wr_en (no wait)
//
// Each accepted sample first drops the entries that have aged out of the window,
// then the restoring divider (one quotient bit per cycle over the 22-bit sum)
// divides the running sum by the count of held entries.
// Reset is synchronous and active high; it clears the store pointers, the
// running sum and restores the window lag to 1000 ticks.
// A finished result waits in the output register while the next beat is taken.
module time_window_moving_average (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  twma_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output twma_pkg::out_t               out_data,
  input  logic                         cfg_wr_en,
  input  logic [twma_pkg::TIME_W-1:0]  cfg_wr_data
);
  import twma_pkg::*;

  // The controller sequences each sample through these steps: drop the
  // oldest entry if the store is full, append the new one, then compare the
  // age of the oldest entry against the lag and drop it while it is too old and
  // not the only entry. Each drop passes the settle state so the registered read
  // follows the new oldest position. Finally the sum is divided by the count.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  twma_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cmd         (cmd),
    .stat        (stat)
  );

  twma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

endmodule

FILE: rtl/twma_div.sv
module twma_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [twma_pkg::SUM_W-1:0]    dividend,
  input  logic [twma_pkg::CNT_W-1:0]    divisor,
  output logic                          done,
  output logic [twma_pkg::SUM_W-1:0]    quotient
);
  import twma_pkg::*;

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [REM_W-1:0]  rem;
  logic [SUM_W-1:0]  dvd;
  logic [CNT_W-1:0]  dvr;
  logic              neg;

  logic [REM_W-1:0]  trial;
  logic              fits;
  logic [REM_W-1:0]  rem_next;

  // One quotient bit per cycle, restoring form on the magnitude.
  always_comb begin
    trial    = {rem[REM_W-2:0], dvd[SUM_W-1]};
    fits     = trial >= {1'b0, dvr};
    rem_next = fits ? trial - {1'b0, dvr} : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(SUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
      dvr <= divisor;
      neg <= dividend[SUM_W-1];
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[SUM_W-2:0], fits};
    end
  end

  assign quotient = neg ? (~dvd + 1'b1) : dvd;

endmodule

FILE: rtl/twma_dp.sv
module twma_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  twma_pkg::in_t                in_data,
  input  logic                         cfg_wr_en,
  input  logic [twma_pkg::TIME_W-1:0]  cfg_wr_data,
  input  logic                         out_stall,
  output logic                         out_valid,
  output twma_pkg::out_t               out_data,
  input  twma_pkg::dp_cmd_t            cmd,
  output twma_pkg::dp_stat_t           stat
);
  import twma_pkg::*;

  entry_t                     mem [DEPTH];
  entry_t                     rd;

  logic signed [SAMPLE_W-1:0] smp;
  logic [TIME_W-1:0]          now;
  logic [TIME_W-1:0]          lag;
  logic [IDX_W-1:0]           oldest;
  logic [CNT_W-1:0]           count;
  logic signed [SUM_W-1:0]    sum;

  logic [IDX_W:0]             pos_raw;
  logic [IDX_W-1:0]           pos;
  logic [IDX_W-1:0]           oldest_inc;
  logic [TIME_W-1:0]          age;
  logic                       div_done;
  logic [SUM_W-1:0]           quotient;

  always_comb begin
    pos_raw = (IDX_W+1)'(oldest) + (IDX_W+1)'(count);
    if (pos_raw >= (IDX_W+1)'(DEPTH)) begin
      pos = IDX_W'(pos_raw - (IDX_W+1)'(DEPTH));
    end else begin
      pos = IDX_W'(pos_raw);
    end
    oldest_inc = (oldest == IDX_W'(DEPTH - 1)) ? '0 : oldest + 1'b1;
    age        = now - rd.stamp;
  end

  // The read port always follows the oldest entry.
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem[pos] <= '{sample: smp, stamp: now};
    end
    rd <= mem[oldest];
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      smp <= in_data.sample_value;
      now <= in_data.timestamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lag <= LAG_RESET;
    end else if (cfg_wr_en) begin
      lag <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest <= '0;
      count  <= '0;
      sum    <= '0;
    end else if (cmd.drop) begin
      oldest <= oldest_inc;
      count  <= count - 1'b1;
      sum    <= sum - SUM_W'(rd.sample);
    end else if (cmd.append) begin
      count  <= count + 1'b1;
      sum    <= sum + SUM_W'(smp);
    end
  end

  twma_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum),
    .divisor  (count),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.average <= quotient[SAMPLE_W-1:0];
      out_data.count   <= COUNT_W'(count);
    end
  end

  always_comb begin
    stat.full     = count == CNT_W'(DEPTH);
    stat.multi    = count > CNT_W'(1);
    stat.aged     = age > lag;
    stat.div_done = div_done;
    stat.out_free = !out_valid || !out_stall;
  end

endmodule

FILE: rtl/twma_ctrl.sv
module twma_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  twma_pkg::dp_stat_t  stat,
  output twma_pkg::dp_cmd_t   cmd
);
  import twma_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DROP_FULL;
        end
      end
      ST_DROP_FULL: state_next = ST_APPEND;
      ST_APPEND:    state_next = ST_SETTLE;
      ST_SETTLE:    state_next = ST_CHECK;
      ST_CHECK: begin
        if (stat.multi && stat.aged) begin
          state_next = ST_SETTLE;
        end else begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (stat.div_done) begin
          state_next = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
      end
      ST_DROP_FULL: cmd.drop = stat.full;
      ST_APPEND:    cmd.append = 1'b1;
      ST_CHECK: begin
        cmd.drop      = stat.multi && stat.aged;
        cmd.div_start = !(stat.multi && stat.aged);
      end
      ST_DELIVER:   cmd.load_out = stat.out_free;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

FILE: rtl/twma_chk.sv
`include "assert_macros.svh"

module twma_chk (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  twma_pkg::out_t               out_data
);
  import twma_pkg::*;

  logic in_beat;
  logic count_ok;

  assign in_beat  = in_valid && !in_stall;
  assign count_ok = (out_data.count != '0) && (out_data.count <= COUNT_W'(DEPTH));

  // A taken sample keeps the block busy in the following cycle.
  `ASSERT_NEXT(a_busy_after_beat, in_beat, in_stall, "input not stalled after a beat")

  // A result shows a count between one and the store depth.
  `ASSERT_IMPLY(a_count_range, out_valid, count_ok, "result count out of range")

  // A new result appears only as the block returns to waiting for input.
  `ASSERT_IMPLY(a_result_then_ready, $rose(out_valid), !in_stall, "result loaded while busy")

  // A stalled result holds.
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind time_window_moving_average twma_chk u_chk (.*);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import twma_pkg::*;

  // Each item passes through pruning and the divide inside the block, and the
  // receiver and sender idle on top of that. This limit is several times the
  // slowest legal run of roughly 750 items.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned TAIL_CYCLES = 200;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_wr_en = 1'b0;
  logic [TIME_W-1:0] cfg_wr_data = '0;

  time_window_moving_average dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state. It mirrors the window store: a circular buffer of samples
  // and their timestamps, the position of the oldest entry, how many entries
  // are held and the running sum of the held samples.
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] held_sample [DEPTH];
  logic [TIME_W-1:0]          held_stamp  [DEPTH];
  int unsigned                oldest_slot = 0;
  int unsigned                held_count  = 0;
  longint                     window_sum  = 0;
  logic [TIME_W-1:0]          window_lag_now = LAG_RESET;

  out_t        expected_means[$];
  int unsigned fail_count     = 0;
  int unsigned samples_sent   = 0;
  int unsigned means_checked  = 0;
  int unsigned lag_settings   = 0;
  int unsigned deepest_window = 0;
  int unsigned overflow_drops = 0;
  int unsigned cycle_count    = 0;

  function automatic void retire_oldest();
    window_sum  -= longint'(held_sample[oldest_slot]);
    oldest_slot  = (oldest_slot + 1) % DEPTH;
    held_count--;
  endfunction

  // Appends one predicted mean at the tail of the expected queue.
  function automatic void enqueue_mean(input out_t mean);
    expected_means.insert(expected_means.size(), mean);
  endfunction

  // Works out the mean and count that one accepted sample must produce and
  // advances the predictor state to match.
  function automatic out_t predict_mean(in_t item);
    out_t              mean;
    int unsigned       slot;
    logic [TIME_W-1:0] age;
    bit                settled;
    // A full store gives up its oldest entry before the new one goes in.
    if (held_count == DEPTH) begin
      retire_oldest();
      overflow_drops++;
    end
    slot             = (oldest_slot + held_count) % DEPTH;
    held_sample[slot] = item.sample_value;
    held_stamp[slot]  = item.timestamp;
    held_count++;
    window_sum += longint'($signed(item.sample_value));
    // Age is a modular difference, so a stamp that went backwards makes the
    // older entries look ancient. Pruning stops at the first young entry and
    // never removes the newest one.
    settled = 1'b0;
    while (held_count > 1 && !settled) begin
      age = item.timestamp - held_stamp[oldest_slot];
      if (age > window_lag_now) begin
        retire_oldest();
      end else begin
        settled = 1'b1;
      end
    end
    if (held_count > deepest_window) begin
      deepest_window = held_count;
    end
    // Signed division of the sum truncates toward zero.
    mean.average = SAMPLE_W'(window_sum / longint'(held_count));
    mean.count   = COUNT_W'(held_count);
    return mean;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Called right after a rising edge; raises valid with the beat and
  // holds both until the block takes it. Valid is only lowered for a gap, so
  // back-to-back beats never see valid dropped and raised in one step.
  // ---------------------------------------------------------------------------
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value,
                             input logic [TIME_W-1:0] stamp,
                             input int unsigned gap);
    in_t item;
    item.sample_value = value;
    item.timestamp    = stamp;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    enqueue_mean(predict_mean(item));
    samples_sent++;
  endtask

  // Lets every outstanding mean come back. Each sample yields exactly one
  // mean, so an empty queue means the block has gone idle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_means.size() != 0) @(posedge clk);
  endtask

  task automatic set_window(input logic [TIME_W-1:0] lag);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lag;
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
    window_lag_now  = lag;
    lag_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Random content. Samples favor the rails and values near zero so that the
  // sum swings hard and truncation toward zero shows up on odd negative sums.
  // ---------------------------------------------------------------------------
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      return 16'sh7FFF;
    end else if (pick == 1) begin
      return 16'sh8000;
    end else if (pick < 4) begin
      return SAMPLE_W'($signed($urandom_range(0, 16)) - 8);
    end else begin
      return SAMPLE_W'($urandom);
    end
  endfunction

  // Mostly a well-formed stream: steps small against the lag so the window
  // grows deep, repeated stamps, some jumps past the lag that flush the
  // window, and a few stamps that go backwards.
  function automatic logic [TIME_W-1:0] next_stamp(input logic [TIME_W-1:0] prev,
                                                   input logic [TIME_W-1:0] lag);
    longint unsigned span;
    int unsigned     pick;
    span = (lag > 32'h00FF_FFFF) ? 64'h00FF_FFFF : 64'(lag);
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      return prev;
    end else if (pick < 85) begin
      return prev + $urandom_range(0, 32'(span / 64'd24) + 32'd1);
    end else if (pick < 95) begin
      return prev + lag + 32'd1 + $urandom_range(0, 1000);
    end else begin
      return prev - $urandom_range(1, 5000);
    end
  endfunction

  task automatic run_random_stream(input logic [TIME_W-1:0] lag,
                                   input int unsigned n_items);
    logic [TIME_W-1:0] stamp;
    int unsigned       burst_left;
    int unsigned       gap;
    set_window(lag);
    stamp      = $urandom;
    burst_left = 0;
    for (int unsigned i = 0; i < n_items; i++) begin
      gap = 0;
      // Bursts of random length; the gap between bursts is long enough to
      // land on any stage of the divide or pruning, and sometimes absent.
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
      end
      burst_left--;
      stamp = next_stamp(stamp, lag);
      send_sample(pick_sample(), stamp, gap);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests.
  // ---------------------------------------------------------------------------

  // Runs on the lag left by reset (1000 ticks): rail samples, an entry whose
  // age equals the lag exactly, pruning of several entries at once, a stamp
  // that goes backwards, and a stamp that wraps past 2^32.
  task automatic test_default_lag();
    send_sample(16'sh7FFF, 32'd100, 0);
    send_sample(16'sh7FFF, 32'd100, 0);
    send_sample(16'sh8000, 32'd150, 0);
    send_sample(16'sh8000, 32'd1100, 0);
    send_sample(-16'sd1, 32'd1101, 0);
    send_sample(16'sd0, 32'd1101, 0);
    send_sample(16'sd5, 32'd500, 0);
    send_sample(-16'sd7, 32'hFFFF_FF00, 0);
    send_sample(16'sd2, 32'h0000_0100, 0);
  endtask

  // With no lag only entries stamped exactly like the newest survive.
  task automatic test_zero_lag();
    set_window(32'd0);
    send_sample(16'sd100, 32'h0000_0100, 0);
    send_sample(-16'sd100, 32'h0000_0101, 0);
    send_sample(16'sd9, 32'h0000_0101, 0);
  endtask

  // A young oldest entry stops the pruning even though an entry behind it
  // carries a later stamp than the newest and so looks very old.
  task automatic test_young_oldest();
    set_window(32'd100);
    send_sample(16'sd1000, 32'h0000_1000, 0);
    send_sample(16'sd2000, 32'h0000_1050, 0);
    send_sample(-16'sd3000, 32'h0000_1040, 0);
    send_sample(16'sd7, 32'h0000_1064, 0);
    send_sample(16'sd7, 32'h0000_1065, 0);
  endtask

  // With the largest lag nothing ever ages out, so the store fills and the
  // oldest entry is pushed out by each new one.
  task automatic test_store_overflow();
    run_random_stream(32'hFFFF_FFFF, 130);
  endtask

  task automatic test_window_sweep();
    run_random_stream(32'd0, 115);
    run_random_stream(32'd1000, 115);
    run_random_stream($urandom_range(1, 200), 115);
    run_random_stream(32'h8000_0000, 115);
    run_random_stream($urandom, 115);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver. The stall pattern switches between never stalling, a coin flip
  // each cycle and mostly stalled, each held for a random stretch.
  // ---------------------------------------------------------------------------
  logic [1:0]  stall_mode = 2'd0;
  int unsigned stall_left = 0;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= 2'($urandom_range(0, 2));
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      2'd0: begin
        out_stall <= 1'b0;
      end
      2'd1: begin
        out_stall <= 1'($urandom_range(0, 1));
      end
      default: begin
        out_stall <= ($urandom_range(0, 15) < 12);
      end
    endcase
  end

  // Every accepted mean is compared with the oldest prediction.
  out_t want_mean;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_means.size() == 0) begin
        $error("unexpected mean beat: average %0d count %0d",
               $signed(out_data.average), out_data.count);
        fail_count++;
      end else begin
        want_mean = expected_means.pop_front();
        if (out_data.average !== want_mean.average) begin
          $error("average: expected %0d, got %0d",
                 $signed(want_mean.average), $signed(out_data.average));
          fail_count++;
        end
        if (out_data.count !== want_mean.count) begin
          $error("count: expected %0d, got %0d", want_mean.count, out_data.count);
          fail_count++;
        end
        means_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d means outstanding",
               cycle_count, expected_means.size());
      $display("[time_window_moving_average] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_default_lag();
    test_zero_lag();
    test_young_oldest();
    test_store_overflow();
    test_window_sweep();
    wait_drained();
    // Anything the block still emits after this would be a stray beat.
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d samples and %0d means over %0d lag writes",
             samples_sent, means_checked, lag_settings);
    $display("deepest window %0d entries, %0d entries pushed out of a full store",
             deepest_window, overflow_drops);
    if (fail_count == 0) begin
      $display("[time_window_moving_average] OK");
    end else begin
      $display("[time_window_moving_average] ERROR");
    end
    $finish;
  end

endmodule
